### rtl/core/register_scoreboard_hazard_check_core_assert.svh
// Assertion macros shared by the scoreboard modules.
`ifndef REGISTER_SCOREBOARD_HAZARD_CHECK_CORE_ASSERT_SVH
`define REGISTER_SCOREBOARD_HAZARD_CHECK_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define RSHC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rshc assertion failed");
// Next-cycle implication
`define RSHC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rshc assertion failed");
`else
`define RSHC_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define RSHC_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

### rtl/core/rshc_pkg.sv
`default_nettype none

package rshc_pkg;

  localparam int REG_IDX_W = 5;
  localparam int CODE_W    = 8;

  // Operation codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Instruction formats
  localparam logic [2:0] ENC_R  = 3'd0;
  localparam logic [2:0] ENC_R4 = 3'd1;
  localparam logic [2:0] ENC_I  = 3'd2;
  localparam logic [2:0] ENC_S  = 3'd3;
  localparam logic [2:0] ENC_B  = 3'd4;
  localparam logic [2:0] ENC_U  = 3'd5;
  localparam logic [2:0] ENC_J  = 3'd6;

  typedef struct packed {
    logic                 op;
    logic [2:0]           encoding;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [REG_IDX_W-1:0] rs3;
    logic                 dst_is_float;
    logic                 src_is_float;
    logic                 long_latency;
    logic [CODE_W-1:0]    type_code;
  } item_t;

  typedef struct packed {
    logic              stall_res;
    logic [CODE_W-1:0] stall_type;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    SEL_RD,
    SEL_RS1,
    SEL_RS2,
    SEL_RS3
  } reg_sel_t;

  // One checked register: which file and which index field
  typedef struct packed {
    logic     use_dst;
    reg_sel_t sel;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       read;
    logic [1:0] slot;
    logic       check;
    logic       finish;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       op;
    logic [2:0] nslots;
    logic       hit;
  } dp_status_t;

  // Number of registers a format checks
  function automatic logic [2:0] slot_count(input logic [2:0] enc);
    logic [2:0] n;
    case (enc)
      ENC_R:          n = 3'd3;
      ENC_R4:         n = 3'd4;
      ENC_I, ENC_S:   n = 3'd2;
      ENC_B:          n = 3'd2;
      ENC_U, ENC_J:   n = 3'd1;
      default:        n = 3'd0;
    endcase
    return n;
  endfunction

  // Register checked at a given position, in check order
  function automatic slot_t slot_lookup(input logic [2:0] enc, input logic [1:0] pos);
    slot_t s;
    s = '{use_dst: 1'b1, sel: SEL_RD};
    case (enc)
      ENC_R, ENC_R4, ENC_I: begin
        case (pos)
          2'd0:    s = '{use_dst: 1'b1, sel: SEL_RD};
          2'd1:    s = '{use_dst: 1'b0, sel: SEL_RS1};
          2'd2:    s = '{use_dst: 1'b0, sel: SEL_RS2};
          default: s = '{use_dst: 1'b0, sel: SEL_RS3};
        endcase
      end
      ENC_S: begin
        // store: rs2 is looked up in the destination file first
        if (pos == 2'd0) s = '{use_dst: 1'b1, sel: SEL_RS2};
        else             s = '{use_dst: 1'b0, sel: SEL_RS1};
      end
      ENC_B: begin
        if (pos == 2'd0) s = '{use_dst: 1'b0, sel: SEL_RS1};
        else             s = '{use_dst: 1'b0, sel: SEL_RS2};
      end
      default: s = '{use_dst: 1'b1, sel: SEL_RD};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/register_scoreboard_hazard_check_core.sv
// Register scoreboard for an issue stage: pending type codes for the integer
// and float register files.
// Input: a word on item is taken at a clock edge where start is high and busy
// is low. op selects a hazard check (with issue on no hazard) or a clear of
// one register's entry.
// Output: one result word per input word, shown on result for a single cycle
// while done is high. The receiver cannot stall; it must take it then.
// For a check, each looked-up register (k = 1..4 by format) takes one read
// of the single code-memory read port, then a compare; the walk stops at the
// first nonzero code. Finish follows and raises done. A clear or an unused
// format goes from the read state straight to finish. busy stays high through
// the done cycle, so no new word is taken while one is in flight.
// Table state is written in the done cycle, before the next word is read.
// Reset (rst, synchronous): all pending codes read as zero at once through
// per-entry valid bits; no clearing pass is needed.
`default_nettype none

module register_scoreboard_hazard_check_core #(
  parameter int NUM_REGS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  rshc_pkg::item_t          item,
  output logic                     done,
  output rshc_pkg::result_t        result
);

  rshc_pkg::ctl_cmd_t   cmd;
  rshc_pkg::dp_status_t status;

  rshc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  rshc_dpath #(
    .NUM_REGS (NUM_REGS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

`default_nettype wire

### rtl/core/rshc_ctrl.sv
`default_nettype none

`include "register_scoreboard_hazard_check_core_assert.svh"

module rshc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  rshc_pkg::dp_status_t status,
  output rshc_pkg::ctl_cmd_t  cmd
);

  rshc_pkg::ctl_state_t state, state_next;
  logic [1:0] slot, slot_next;

  // state and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rshc_pkg::ST_IDLE;
      slot  <= 2'd0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    slot_next  = slot;
    cmd        = '0;
    cmd.slot   = slot;
    case (state)
      rshc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          slot_next  = 2'd0;
          state_next = rshc_pkg::ST_READ;
        end
      end
      rshc_pkg::ST_READ: begin
        // clear words and unused formats skip the lookups
        if (status.op == rshc_pkg::OP_CLEAR || status.nslots == 3'd0) begin
          state_next = rshc_pkg::ST_FINISH;
        end else begin
          cmd.read   = 1'b1;
          state_next = rshc_pkg::ST_CHECK;
        end
      end
      rshc_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (status.hit || ({1'b0, slot} + 3'd1) == status.nslots) begin
          state_next = rshc_pkg::ST_FINISH;
        end else begin
          slot_next  = slot + 2'd1;
          state_next = rshc_pkg::ST_READ;
        end
      end
      rshc_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = rshc_pkg::ST_IDLE;
      end
      default: state_next = rshc_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != rshc_pkg::ST_IDLE);
  assign done = (state == rshc_pkg::ST_FINISH);

  `RSHC_ASSERT_NXT(a_busy_after_accept, clk, rst, start && !busy, busy)
  `RSHC_ASSERT_NXT(a_single_done, clk, rst, done, !done)
  `RSHC_ASSERT_IMP(a_check_after_read, clk, rst, state == rshc_pkg::ST_CHECK, $past(state) == rshc_pkg::ST_READ)

endmodule

`default_nettype wire

### rtl/core/rshc_dpath.sv
`default_nettype none

`include "register_scoreboard_hazard_check_core_assert.svh"

module rshc_dpath #(
  parameter int NUM_REGS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rshc_pkg::item_t      item,
  input  rshc_pkg::ctl_cmd_t   cmd,
  output rshc_pkg::dp_status_t status,
  output rshc_pkg::result_t    result
);

  localparam int AW        = $clog2(NUM_REGS);
  localparam int XW        = (AW > rshc_pkg::REG_IDX_W) ? AW : rshc_pkg::REG_IDX_W;
  localparam int MEM_DEPTH = 2 * (1 << AW);

  rshc_pkg::item_t   item_q;
  logic [rshc_pkg::CODE_W-1:0] stall_type;

  // pending codes: float file in the upper half
  logic [rshc_pkg::CODE_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]        valid, valid_next;

  rshc_pkg::slot_t             rslot;
  logic                        rfile;
  logic [rshc_pkg::REG_IDX_W-1:0] ridx;
  logic [XW-1:0]               ridx_ext, rd_ext;
  logic [AW:0]                 raddr, waddr;
  logic                        rinrange, rd_inrange;
  logic [rshc_pkg::CODE_W-1:0] rd_data_q, code;
  logic                        rd_hit_q;
  logic                        issue, wr_en, clr0;
  logic [rshc_pkg::CODE_W-1:0] wdata;

  // latched word
  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= item;
  end

  // lookup address for the current slot
  always_comb begin
    rslot = rshc_pkg::slot_lookup(item_q.encoding, cmd.slot);
    rfile = rslot.use_dst ? item_q.dst_is_float : item_q.src_is_float;
    case (rslot.sel)
      rshc_pkg::SEL_RD:  ridx = item_q.rd;
      rshc_pkg::SEL_RS1: ridx = item_q.rs1;
      rshc_pkg::SEL_RS2: ridx = item_q.rs2;
      rshc_pkg::SEL_RS3: ridx = item_q.rs3;
      default:           ridx = item_q.rd;
    endcase
    ridx_ext = XW'(ridx);
    raddr    = {rfile, ridx_ext[AW-1:0]};
    rinrange = (32'(ridx) < NUM_REGS);
  end

  // write side, used at finish
  always_comb begin
    rd_ext     = XW'(item_q.rd);
    waddr      = {item_q.dst_is_float, rd_ext[AW-1:0]};
    rd_inrange = (32'(item_q.rd) < NUM_REGS);
    issue      = cmd.finish && item_q.op == rshc_pkg::OP_CHECK && stall_type == '0;
    clr0       = issue;
    if (item_q.op == rshc_pkg::OP_CLEAR) begin
      wr_en = cmd.finish && rd_inrange;
      wdata = '0;
    end else begin
      wr_en = issue && rd_inrange && item_q.long_latency &&
              item_q.encoding != rshc_pkg::ENC_B && item_q.encoding != rshc_pkg::ENC_S;
      wdata = item_q.type_code;
    end
  end

  // valid bits: entry 0 of the integer file is zeroed first, then the record
  always_comb begin
    valid_next = valid;
    if (clr0) valid_next[0] = 1'b0;
    if (wr_en) valid_next[waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else     valid <= valid_next;
  end

  // code memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (cmd.read) begin
      rd_data_q <= mem[raddr];
      rd_hit_q  <= valid[raddr] && rinrange;
    end
  end

  assign code = rd_hit_q ? rd_data_q : '0;

  // first nonzero code found
  always_ff @(posedge clk) begin
    if (cmd.load) stall_type <= '0;
    else if (cmd.check && code != '0) stall_type <= code;
  end

  assign status.op     = item_q.op;
  assign status.nslots = rshc_pkg::slot_count(item_q.encoding);
  assign status.hit    = (code != '0);

  assign result.stall_res  = (stall_type != '0);
  assign result.stall_type = stall_type;

  `RSHC_ASSERT_IMP(a_check_follows_read, clk, rst, cmd.check, $past(cmd.read))
  `RSHC_ASSERT_IMP(a_clear_no_stall, clk, rst, cmd.finish && item_q.op == rshc_pkg::OP_CLEAR, !result.stall_res)

endmodule

`default_nettype wire
